FILE: rtl/cfla_pkg.sv
// shared constants and payload types for the chunked free list allocator
`default_nettype none
package cfla_pkg;
  localparam int CHUNKS_DEF = 8;
  localparam int BLOCKS_PER_CHUNK_DEF = 128;
  localparam int KEEP_EMPTY = 2;
  localparam int EMPTY_MAX = 15;
  localparam int ADDR_W = 17;
  localparam int BB_W = 8;
  localparam int IDX_W = 8;
  localparam int EMPTY_W = 4;
  localparam logic [BB_W-1:0] BB_RESET = 8'd8;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] byte_addr;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] block_addr;
  } rsp_t;

  typedef logic [BB_W-1:0] cfg_t;
endpackage
`default_nettype wire

FILE: rtl/cfla_chan.sv
// valid/ready channel carrying one payload type
`default_nettype none
interface cfla_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/cfla_div.sv
// shared iterative restoring divider, one quotient bit per cycle
`default_nettype none
module cfla_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cfla_pkg::ADDR_W-1:0] dividend,
  input  wire logic [cfla_pkg::ADDR_W-1:0] divisor,
  output logic                            done,
  output logic [cfla_pkg::ADDR_W-1:0]     quot,
  output logic [cfla_pkg::ADDR_W-1:0]     rem
);
  localparam int W = cfla_pkg::ADDR_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       shifted;
  logic             fits;

  assign shifted = {rem, quot[W-1]};
  assign fits = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(W);
        quot <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= W'(shifted - {1'b0, dvs});
        end else begin
          rem <= W'(shifted);
        end
        quot <= {quot[W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cfla_link_mem.sv
// link store, one write and one registered read port
`default_nettype none
module cfla_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [cfla_pkg::IDX_W-1:0]   wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic [cfla_pkg::IDX_W-1:0]        rdata
);
  logic [cfla_pkg::IDX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/chunked_free_list_allocator.sv
// top level: chunked fixed-size block allocator with a sequencer over shared units
//
// channels: req (sink) carries req_type and byte_addr; rsp (source) returns ok and
// block_addr, one result per request; cfg (sink) writes block_bytes, always ready;
// it must be written only while the block is idle; the block does not enforce it.
// the block takes one request at a time; req.ready is high only while idle.
// an allocate hitting the hint chunk steps through S_TRY, S_TAKE (pops the head
// from the link store), S_ADDR (forms the address) and S_DONE; each further chunk
// tried in the scan adds a pass through S_TRY; activating a chunk adds S_FIND over
// the chunks looked at and S_RELINK, which re-links its free list through the
// single write port of the link store. a free runs two passes of the shared
// divider (address by chunk span, then the remainder by block size), pushes the
// block in S_GIVE, and on retiring chunks scans every chunk and fixes the hints.
// after reset the block re-links chunk zero before req.ready rises; heads, hints
// and the empty count are cleared at once, counts set to full, chunk zero active.
// a finished result sits in the rsp register; while the receiver stalls the block
// may take one more request and then holds in its done state until it is free.
`default_nettype none
module chunked_free_list_allocator #(
  parameter int CHUNKS = cfla_pkg::CHUNKS_DEF,
  parameter int BLOCKS_PER_CHUNK = cfla_pkg::BLOCKS_PER_CHUNK_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cfla_chan.sink   req,
  cfla_chan.source rsp,
  cfla_chan.sink   cfg
);
  localparam int AW_ = cfla_pkg::ADDR_W;
  localparam int IW = cfla_pkg::IDX_W;
  localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DEPTH = CHUNKS * BLOCKS_PER_CHUNK;
  localparam int MAW = $clog2(DEPTH);
  localparam int LW = CW + IW;
  localparam int EW = cfla_pkg::EMPTY_W;

  typedef enum logic [3:0] {
    S_RELINK, S_IDLE, S_TRY, S_TAKE, S_ADDR, S_FIND, S_DONE,
    S_DIV1, S_DIV2, S_GIVE, S_SHCHK, S_SHRINK, S_HINTFIX
  } state_t;

  typedef enum logic [1:0] {P_HINT, P_SCAN, P_ACT} phase_t;

  state_t                  state;
  phase_t                  phase;
  logic                    relink_init;
  logic [CW-1:0]           cur;
  logic [IW-1:0]           ri;
  logic [IW-1:0]           gidx;
  logic                    hit;
  logic [IW-1:0]           head [CHUNKS];
  logic [IW-1:0]           count [CHUNKS];
  logic [CHUNKS-1:0]       active;
  logic [CW-1:0]           alloc_hint;
  logic [CW-1:0]           free_hint;
  logic [EW-1:0]           empty_count;
  logic [1:0]              nempty;
  logic [CW-1:0]           low_act;
  logic                    low_found;
  logic [LW-1:0]           lin;
  logic [cfla_pkg::BB_W-1:0] block_bytes;
  logic                    res_ok;
  logic [AW_-1:0]          res_addr;

  logic [cfla_pkg::BB_W-1:0] eff_bb;
  logic [AW_-1:0]          span;
  logic [IW-1:0]           idx_sel;
  logic [LW-1:0]           lin_w;
  logic [MAW-1:0]          maddr;
  logic                    mem_we;
  logic [IW-1:0]           mem_wdata;
  logic [IW-1:0]           mem_rdata;
  logic                    take_ok;
  logic [LW+cfla_pkg::BB_W-1:0] prod;
  logic                    div_start;
  logic [AW_-1:0]          div_dividend;
  logic [AW_-1:0]          div_divisor;
  logic                    div_done;
  logic [AW_-1:0]          div_quot;
  logic [AW_-1:0]          div_rem;
  logic                    req_xfer;
  logic                    ch_hit;
  logic                    retire;
  logic [1:0]              nempty_inc;

  assign eff_bb = (block_bytes == '0) ? cfla_pkg::BB_W'(1) : block_bytes;
  assign span = AW_'(BLOCKS_PER_CHUNK) * AW_'(eff_bb);
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_xfer = req.valid && req.ready;

  always_comb begin
    case (state)
      S_GIVE: idx_sel = gidx;
      S_RELINK: idx_sel = ri;
      default: idx_sel = head[cur];
    endcase
  end

  assign lin_w = LW'(cur) * LW'(BLOCKS_PER_CHUNK) + LW'(idx_sel);
  assign maddr = MAW'(lin_w);
  assign take_ok = active[cur] && (count[cur] != '0) && (head[cur] < IW'(BLOCKS_PER_CHUNK));
  assign prod = (LW+cfla_pkg::BB_W)'(lin) * (LW+cfla_pkg::BB_W)'(eff_bb);
  assign ch_hit = (div_quot < AW_'(CHUNKS)) && active[CW'(div_quot)];
  assign retire = active[cur] && (count[cur] == IW'(BLOCKS_PER_CHUNK)) && (nempty >= 2'd2);
  assign nempty_inc = (nempty == 2'd3) ? 2'd3 : nempty + 2'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = head[cur];
    if (state == S_RELINK) begin
      mem_we = 1'b1;
      mem_wdata = ri + 1'b1;
    end else if (state == S_GIVE) begin
      mem_we = hit && (count[cur] < IW'(BLOCKS_PER_CHUNK));
    end
  end

  assign div_start = (req_xfer && req.data.req_type == cfla_pkg::REQ_FREE)
                  || (state == S_DIV1 && div_done);
  assign div_dividend = (state == S_IDLE) ? req.data.byte_addr : div_rem;
  assign div_divisor = (state == S_IDLE) ? span : AW_'(eff_bb);

  cfla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  cfla_link_mem #(.DEPTH(DEPTH), .AW(MAW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (maddr),
    .wdata (mem_wdata),
    .raddr (maddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RELINK;
      relink_init <= 1'b1;
      phase <= P_HINT;
      cur <= '0;
      ri <= '0;
      for (int c = 0; c < CHUNKS; c++) begin
        head[c] <= '0;
        count[c] <= IW'(BLOCKS_PER_CHUNK);
      end
      active <= CHUNKS'(1);
      alloc_hint <= '0;
      free_hint <= '0;
      empty_count <= '0;
      block_bytes <= cfla_pkg::BB_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        block_bytes <= cfg.data;
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_RELINK: begin
          ri <= ri + 1'b1;
          if (ri == IW'(BLOCKS_PER_CHUNK - 1)) begin
            ri <= '0;
            head[cur] <= '0;
            count[cur] <= IW'(BLOCKS_PER_CHUNK);
            relink_init <= 1'b0;
            state <= relink_init ? S_IDLE : S_TRY;
          end
        end
        S_IDLE: begin
          if (req_xfer) begin
            res_ok <= 1'b0;
            res_addr <= '0;
            if (req.data.req_type == cfla_pkg::REQ_ALLOC) begin
              phase <= P_HINT;
              cur <= alloc_hint;
              state <= S_TRY;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_TRY: begin
          if (take_ok) begin
            state <= S_TAKE;
          end else if (phase == P_HINT) begin
            phase <= P_SCAN;
            cur <= '0;
          end else if (phase == P_SCAN && cur != CW'(CHUNKS - 1)) begin
            cur <= cur + 1'b1;
          end else if (phase == P_SCAN) begin
            phase <= P_ACT;
            cur <= '0;
            state <= S_FIND;
          end else begin
            state <= S_DONE;
          end
        end
        S_FIND: begin
          if (!active[cur]) begin
            active[cur] <= 1'b1;
            alloc_hint <= cur;
            free_hint <= cur;
            ri <= '0;
            state <= S_RELINK;
          end else if (cur == CW'(CHUNKS - 1)) begin
            state <= S_DONE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_TAKE: begin
          head[cur] <= mem_rdata;
          count[cur] <= count[cur] - 1'b1;
          alloc_hint <= cur;
          lin <= lin_w;
          state <= S_ADDR;
        end
        S_ADDR: begin
          res_ok <= 1'b1;
          res_addr <= AW_'(prod);
          state <= S_DONE;
        end
        S_DIV1: begin
          if (div_done) begin
            cur <= CW'(div_quot);
            hit <= ch_hit;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            gidx <= IW'(div_quot);
            state <= S_GIVE;
          end
        end
        S_GIVE: begin
          res_ok <= hit;
          if (hit && count[cur] < IW'(BLOCKS_PER_CHUNK)) begin
            head[cur] <= gidx;
            count[cur] <= count[cur] + 1'b1;
            if (count[cur] == IW'(BLOCKS_PER_CHUNK - 1)
                && empty_count < EW'(cfla_pkg::EMPTY_MAX)) begin
              empty_count <= empty_count + 1'b1;
            end
          end
          if (hit && cur == free_hint) begin
            state <= S_DONE;
          end else begin
            if (hit) begin
              free_hint <= cur;
            end
            state <= S_SHCHK;
          end
        end
        S_SHCHK: begin
          cur <= '0;
          nempty <= '0;
          low_act <= '0;
          low_found <= 1'b0;
          state <= (empty_count > EW'(cfla_pkg::KEEP_EMPTY)) ? S_SHRINK : S_DONE;
        end
        S_SHRINK: begin
          if (active[cur] && count[cur] == IW'(BLOCKS_PER_CHUNK)) begin
            nempty <= nempty_inc;
          end
          if (retire) begin
            active[cur] <= 1'b0;
          end else if (active[cur] && !low_found) begin
            low_act <= cur;
            low_found <= 1'b1;
          end
          if (cur == CW'(CHUNKS - 1)) begin
            empty_count <= EW'(cfla_pkg::KEEP_EMPTY);
            state <= S_HINTFIX;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_HINTFIX: begin
          if (!active[alloc_hint]) begin
            alloc_hint <= low_act;
          end
          if (!active[free_hint]) begin
            free_hint <= low_act;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.data.ok <= res_ok;
            rsp.data.block_addr <= res_addr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cfla_checker.sv
// port checker for the allocator, bound to the top level
`default_nettype none
module cfla_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic                        rsp_ok,
  input wire logic [cfla_pkg::ADDR_W-1:0] rsp_addr
);
  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // a failed result carries a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_addr == '0)
    else $error("nonzero address on failed result");

  // a busy block stays busy while its last result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && !req_ready |=> !req_ready)
    else $error("result lost");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_ok))
    else $error("stalled result changed");
endmodule

bind chunked_free_list_allocator cfla_checker u_cfla_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_ok    (rsp.data.ok),
  .rsp_addr  (rsp.data.block_addr)
);
`default_nettype wire

FILE: verif/chunked_free_list_allocator_test.sv
// testbench for the chunked free list allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module chunked_free_list_allocator_test;
  localparam int NCH = cfla_pkg::CHUNKS_DEF;
  localparam int NBLK = cfla_pkg::BLOCKS_PER_CHUNK_DEF;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cfla_chan #(.T(cfla_pkg::req_t)) req_if ();
  cfla_chan #(.T(cfla_pkg::rsp_t)) rsp_if ();
  cfla_chan #(.T(cfla_pkg::cfg_t)) cfg_if ();

  chunked_free_list_allocator u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // predicted allocator state
  logic [7:0] link_q [NCH*NBLK];
  logic [7:0] head_q [NCH];
  int         free_cnt [NCH];
  bit         active_q [NCH];
  int         alloc_hint_q;
  int         free_hint_q;
  int         empty_cnt;
  int         blk_bytes;

  cfla_pkg::rsp_t expected_rsps [$];
  logic [cfla_pkg::ADDR_W-1:0] live_blocks [$];
  int         errors = 0;
  int         cycles = 0;
  int         n_rsp = 0;
  int         n_shrink = 0;
  int         hold_cycles = 0;
  bit         quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_bytes();
    return (blk_bytes == 0) ? 1 : blk_bytes;
  endfunction

  function automatic void relink_chunk(int c);
    for (int i = 0; i < NBLK; i++) link_q[c*NBLK+i] = 8'(i + 1);
    head_q[c] = '0;
    free_cnt[c] = NBLK;
  endfunction

  function automatic void reset_model();
    for (int c = 0; c < NCH; c++) begin
      relink_chunk(c);
      active_q[c] = (c == 0);
    end
    alloc_hint_q = 0;
    free_hint_q = 0;
    empty_cnt = 0;
    blk_bytes = cfla_pkg::BB_RESET;
  endfunction

  function automatic bit take_block(int c, output int addr);
    int idx;
    addr = 0;
    if (!active_q[c] || free_cnt[c] == 0) return 1'b0;
    idx = head_q[c];
    if (idx >= NBLK) return 1'b0;
    head_q[c] = link_q[c*NBLK+idx];
    free_cnt[c]--;
    addr = (c * NBLK + idx) * eff_bytes();
    return 1'b1;
  endfunction

  function automatic void give_block(int c, int idx);
    if (free_cnt[c] >= NBLK) return;
    link_q[c*NBLK+idx] = head_q[c];
    head_q[c] = 8'(idx);
    free_cnt[c]++;
    if (free_cnt[c] == NBLK && empty_cnt < cfla_pkg::EMPTY_MAX) empty_cnt++;
  endfunction

  function automatic int lowest_active();
    for (int c = 0; c < NCH; c++) if (active_q[c]) return c;
    return 0;
  endfunction

  function automatic void retire_empty();
    int n;
    n = 0;
    for (int c = 0; c < NCH; c++) begin
      if (active_q[c] && free_cnt[c] == NBLK) begin
        n++;
        if (n > cfla_pkg::KEEP_EMPTY) active_q[c] = 1'b0;
      end
    end
    empty_cnt = cfla_pkg::KEEP_EMPTY;
    if (!active_q[alloc_hint_q]) alloc_hint_q = lowest_active();
    if (!active_q[free_hint_q]) free_hint_q = lowest_active();
    n_shrink++;
  endfunction

  function automatic cfla_pkg::rsp_t predict_alloc_free(cfla_pkg::req_t r);
    cfla_pkg::rsp_t res;
    int addr, a, eb, span, ch, idx;
    bit ok;
    addr = 0;
    if (r.req_type == cfla_pkg::REQ_ALLOC) begin
      ok = take_block(alloc_hint_q, addr);
      for (int c = 0; !ok && c < NCH; c++) begin
        if (take_block(c, addr)) begin
          alloc_hint_q = c;
          ok = 1'b1;
        end
      end
      for (int c = 0; !ok && c < NCH; c++) begin
        if (!active_q[c]) begin
          active_q[c] = 1'b1;
          relink_chunk(c);
          ok = take_block(c, addr);
          alloc_hint_q = c;
          free_hint_q = c;
        end
      end
      if (!ok) addr = 0;
    end else begin
      a = int'(r.byte_addr);
      eb = eff_bytes();
      span = NBLK * eb;
      ch = a / span;
      idx = (a % span) / eb;
      ok = 1'b0;
      if (ch == free_hint_q && ch < NCH && active_q[ch]) begin
        give_block(ch, idx);
        ok = 1'b1;
      end else begin
        if (ch < NCH && active_q[ch]) begin
          give_block(ch, idx);
          free_hint_q = ch;
          ok = 1'b1;
        end
        if (empty_cnt > cfla_pkg::KEEP_EMPTY) retire_empty();
      end
      addr = 0;
    end
    res.ok = ok;
    res.block_addr = cfla_pkg::ADDR_W'(addr);
    return res;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_rsp = n_rsp + 1;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result ok=%0b addr=%h", $time, rsp_if.data.ok,
                 rsp_if.data.block_addr);
        errors = errors + 1;
      end else begin
        if (rsp_if.data.ok !== expected_rsps[0].ok) begin
          $display("%0t: ok mismatch expected %0b actual %0b", $time, expected_rsps[0].ok,
                   rsp_if.data.ok);
          errors = errors + 1;
        end
        if (rsp_if.data.block_addr !== expected_rsps[0].block_addr) begin
          $display("%0t: block_addr mismatch expected %h actual %h", $time,
                   expected_rsps[0].block_addr, rsp_if.data.block_addr);
          errors = errors + 1;
        end
        void'(expected_rsps.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  task automatic send_request(input logic kind, input logic [cfla_pkg::ADDR_W-1:0] a,
                              output cfla_pkg::rsp_t res);
    cfla_pkg::req_t r;
    r.req_type = kind;
    r.byte_addr = a;
    if (!quiet && $urandom_range(99) < 14) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    res = predict_alloc_free(r);
    expected_rsps = {expected_rsps, res};
  endtask

  task automatic do_alloc();
    cfla_pkg::rsp_t res;
    send_request(cfla_pkg::REQ_ALLOC, cfla_pkg::ADDR_W'($urandom), res);
    if (res.ok) live_blocks = {live_blocks, res.block_addr};
  endtask

  task automatic do_free(input logic [cfla_pkg::ADDR_W-1:0] a);
    cfla_pkg::rsp_t res;
    send_request(cfla_pkg::REQ_FREE, a, res);
  endtask

  // free a live block, sometimes by an address inside it
  task automatic free_live();
    int k;
    logic [cfla_pkg::ADDR_W-1:0] a;
    k = $urandom_range(live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    if ($urandom_range(3) == 0) a = a + cfla_pkg::ADDR_W'($urandom_range(eff_bytes() - 1));
    do_free(a);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_rsps.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_block_bytes(input int v);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= cfla_pkg::cfg_t'(v);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    blk_bytes = v;
    live_blocks.delete();
  endtask

  task automatic test_directed();
    do_alloc();
    do_alloc();
    do_alloc();
    do_free(live_blocks[0]);
    do_free(cfla_pkg::ADDR_W'(live_blocks[1] + 3));
    do_free(17'h1FFFF);
    do_free(live_blocks[2]);
    do_free(17'h00000);
    live_blocks.delete();
    set_block_bytes(0);
    do_alloc();
    do_alloc();
    do_free(live_blocks[1]);
    do_free(17'h1FFFF);
    set_block_bytes(128);
    do_alloc();
    do_free(cfla_pkg::ADDR_W'(live_blocks[$] + 127));
    do_free(17'h1C000);
    do_free(17'h00000);
    set_block_bytes(cfla_pkg::BB_RESET);
  endtask

  task automatic test_random_mix(input int bb, input int n);
    int p;
    set_block_bytes(bb);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 55 || (p < 90 && live_blocks.size() == 0)) do_alloc();
      else if (p < 90) free_live();
      else do_free(cfla_pkg::ADDR_W'($urandom));
    end
  endtask

  // fill several chunks then drain them so empty chunks get retired
  task automatic test_fill_drain(input int n);
    set_block_bytes(cfla_pkg::BB_RESET);
    quiet = 1'b1;
    for (int i = 0; i < n; i++) do_alloc();
    quiet = 1'b0;
    while (live_blocks.size() != 0) free_live();
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) do_alloc();
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      if (live_blocks.size() != 0) free_live();
      else do_alloc();
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(8, 95);
    test_fill_drain(420);
    test_random_mix(1, 95);
    test_backpressure();
    test_random_mix(128, 95);
    test_random_mix(0, 95);
    test_random_mix($urandom_range(127, 2), 95);
    test_random_mix(cfla_pkg::BB_RESET, 95);
    test_random_mix(8, 95);
    wait_drained();
    repeat (50) @(posedge clk);
    $display("checked %0d results over block sizes 0, 1, 8, 128 and one random size", n_rsp);
    $display("chunk retire passes predicted: %0d, errors: %0d", n_shrink, errors);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/cfla_pkg.sv
rtl/cfla_chan.sv
rtl/cfla_div.sv
rtl/cfla_link_mem.sv
rtl/chunked_free_list_allocator.sv
rtl/cfla_checker.sv
verif/chunked_free_list_allocator_test.sv
